### src/sfim_pkg.sv
// Shared types and constants for the segment face id matcher.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package sfim_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [15:0]        TOL_RESET = 16'd51;
  localparam logic signed [16:0] FACE_NONE = -17'sd1;

  // One stored reference segment
  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] ez;
    logic [15:0]        face;
  } entry_t;

  // Scan controller state
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  // Outcome of comparing one entry
  typedef struct packed {
    logic        valid;
    logic        hit;
    logic [15:0] face;
  } cmp_res_t;

endpackage

### src/segment_face_id_matcher.sv
// Top level of the segment face id matcher: segment ring, compare pipe, scan control.
// Depends on sfim_pkg, sfim_cell and sfim_cmp.
`timescale 1ns / 1ps
// Usage:
//  A command word is taken when start is high and busy is low.
//  cmd_i clear empties the table, load appends a reference segment with its
//  face id (ignored on a full table); busy stays low for both.
//  A query raises busy and rotates the ring of TABLE_DEPTH cells once past
//  the compare pipe, one entry per cycle; the ring ends where it began.
//  The query result is shown for one cycle with result_valid_o high after the
//  scan and the drain of the compare pipe; busy drops the cycle after.
//  Clear and load commands take no result.
//  matched_o / face_id_o give the first matching entry in load order, or
//  0 / -1 when none matched.
//  The tolerance register is written through cfg_valid_i / cfg_ready_o
//  while the block is idle; cfg_ready_o is low while busy.
//  Reset empties the table and sets the tolerance to 51.
//  The receiver cannot stall: each result is shown exactly once.
module segment_face_id_matcher
  import sfim_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd_i,
  input  logic signed [31:0] start_x_i,
  input  logic signed [31:0] start_y_i,
  input  logic signed [31:0] start_z_i,
  input  logic signed [31:0] end_x_i,
  input  logic signed [31:0] end_y_i,
  input  logic signed [31:0] end_z_i,
  input  logic [15:0]        source_face_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_wdata_i,
  output logic               result_valid_o,
  output logic               matched_o,
  output logic signed [16:0] face_id_o
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] step_q;
  logic [1:0]       drain_q;
  logic [15:0]      tol_q;
  entry_t           query_q;
  logic             found_q;
  logic [15:0]      face_q;

  logic             accept;
  logic             do_load;
  logic             rotate;
  logic             shift;
  logic             head_valid;
  entry_t           in_ent;
  entry_t           cell_q [TABLE_DEPTH];
  entry_t           cell_d [TABLE_DEPTH];
  cmp_res_t         cres;

  assign accept  = start && !busy;
  assign do_load = accept && (cmd_i == CMD_LOAD) && (count_q < CNT_W'(TABLE_DEPTH));
  assign rotate  = (state_q == ST_SCAN);
  assign shift   = do_load || rotate;

  assign in_ent = '{sx: start_x_i, sy: start_y_i, sz: start_z_i,
                    ex: end_x_i, ey: end_y_i, ez: end_z_i, face: source_face_i};

  // Ring of cells: loads enter at the tail, a scan feeds the head back to the tail
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign cell_d[i] = do_load ? in_ent : cell_q[0];
    end else begin : g_mid
      assign cell_d[i] = cell_q[i + 1];
    end
    sfim_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .d_i     (cell_d[i]),
      .q_o     (cell_q[i])
    );
  end

  // Valid entries sit in the top count_q cells
  assign head_valid = rotate &&
                      (({1'b0, step_q} + {1'b0, count_q}) >= (CNT_W + 1)'(TABLE_DEPTH));

  sfim_cmp u_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tol_i   (tol_q),
    .valid_i (head_valid),
    .query_i (query_q),
    .entry_i (cell_q[0]),
    .res_o   (cres)
  );

  // Scan sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept && cmd_i == CMD_QUERY) state_d = ST_SCAN;
      ST_SCAN:  if (step_q == CNT_W'(TABLE_DEPTH - 1)) state_d = ST_DRAIN;
      ST_DRAIN: if (drain_q == 2'd1) state_d = ST_DONE;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      step_q  <= '0;
      drain_q <= '0;
      tol_q   <= TOL_RESET;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        tol_q <= cfg_wdata_i;
      end
      if (accept) begin
        case (cmd_i)
          CMD_CLEAR: count_q <= '0;
          CMD_LOAD:  if (do_load) count_q <= count_q + 1'b1;
          CMD_QUERY: begin
            step_q  <= '0;
            drain_q <= '0;
            found_q <= 1'b0;
          end
          default: ;
        endcase
      end
      if (rotate) begin
        step_q <= step_q + 1'b1;
      end
      if (state_q == ST_DRAIN) begin
        drain_q <= drain_q + 1'b1;
      end
      if (cres.valid && cres.hit && !found_q) begin
        found_q <= 1'b1;
      end
    end
  end

  // Query word and first-hit face id
  always_ff @(posedge clk_i) begin
    if (accept && cmd_i == CMD_QUERY) begin
      query_q <= in_ent;
    end
    if (cres.valid && cres.hit && !found_q) begin
      face_q <= cres.face;
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign cfg_ready_o    = !busy;
  assign result_valid_o = (state_q == ST_DONE);
  assign matched_o      = found_q;
  assign face_id_o      = found_q ? $signed({1'b0, face_q}) : FACE_NONE;

`ifndef SYNTH
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i == CMD_QUERY) |=> busy)
    else $error("query accepted without going busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !busy && !result_valid_o)
    else $error("result not followed by idle");

  a_ring_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> !cres.valid || !head_valid)
    else $error("compare fed after scan ended");
`endif

endmodule

### src/sfim_cell.sv
// One storage cell of the segment ring: holds an entry, passes it on when shifting.
// Depends on sfim_pkg.
`timescale 1ns / 1ps
module sfim_cell
  import sfim_pkg::*;
(
  input  logic   clk_i,
  input  logic   shift_i,
  input  entry_t d_i,
  output entry_t q_o
);

  entry_t ent_q;

  // Payload only, no reset
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      ent_q <= d_i;
    end
  end

  assign q_o = ent_q;

endmodule

### src/sfim_cmp.sv
// Three-stage endpoint compare at the head of the ring.
// Depends on sfim_pkg.
`timescale 1ns / 1ps
module sfim_cmp
  import sfim_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] tol_i,
  input  logic        valid_i,
  input  entry_t      query_i,
  input  entry_t      entry_i,
  output cmp_res_t    res_o
);

  // Point pairs: 0 qs-es, 1 qe-ee, 2 qs-ee, 3 qe-es
  logic signed [31:0] pa [4][3];
  logic signed [31:0] pb [4][3];
  logic [3:0]         ok_d;
  logic [15:0]        dif_d [4][3];

  logic [3:0]         ok1_q;
  logic [15:0]        dif1_q [4][3];
  logic               vld1_q;
  logic [15:0]        face1_q;

  logic [3:0]         ok2_q;
  logic [31:0]        sq2_q [4][3];
  logic               vld2_q;
  logic [15:0]        face2_q;

  logic [31:0]        tol_sq_q;
  logic [33:0]        sum [4];
  logic [3:0]         near;

  always_comb begin
    pa[0] = '{query_i.sx, query_i.sy, query_i.sz};
    pb[0] = '{entry_i.sx, entry_i.sy, entry_i.sz};
    pa[1] = '{query_i.ex, query_i.ey, query_i.ez};
    pb[1] = '{entry_i.ex, entry_i.ey, entry_i.ez};
    pa[2] = '{query_i.sx, query_i.sy, query_i.sz};
    pb[2] = '{entry_i.ex, entry_i.ey, entry_i.ez};
    pa[3] = '{query_i.ex, query_i.ey, query_i.ez};
    pb[3] = '{entry_i.sx, entry_i.sy, entry_i.sz};
  end

  // Stage 1: per-axis absolute differences, bounded by the tolerance
  // (two guard bits: the full-range difference needs 33 bits signed)
  always_comb begin
    logic signed [33:0] dd;
    logic [33:0]        ad;
    for (int p = 0; p < 4; p++) begin
      ok_d[p] = 1'b1;
      for (int a = 0; a < 3; a++) begin
        dd = {{2{pa[p][a][31]}}, pa[p][a]} - {{2{pb[p][a][31]}}, pb[p][a]};
        ad = dd[33] ? 34'(-dd) : 34'(dd);
        if (ad > {18'd0, tol_i}) begin
          ok_d[p] = 1'b0;
        end
        dif_d[p][a] = ad[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
    end
  end

  // Stage 2: squares; tolerance squared kept in a register of its own
  always_ff @(posedge clk_i) begin
    ok1_q    <= ok_d;
    dif1_q   <= dif_d;
    face1_q  <= entry_i.face;
    ok2_q    <= ok1_q;
    face2_q  <= face1_q;
    tol_sq_q <= tol_i * tol_i;
    for (int p = 0; p < 4; p++) begin
      for (int a = 0; a < 3; a++) begin
        sq2_q[p][a] <= dif1_q[p][a] * dif1_q[p][a];
      end
    end
  end

  // Stage 3: sum and strict compare
  always_comb begin
    for (int p = 0; p < 4; p++) begin
      sum[p]  = {2'b0, sq2_q[p][0]} + {2'b0, sq2_q[p][1]} + {2'b0, sq2_q[p][2]};
      near[p] = ok2_q[p] && (sum[p] < {2'b0, tol_sq_q});
    end
  end

  assign res_o.valid = vld2_q;
  assign res_o.hit   = (near[0] && near[1]) || (near[2] && near[3]);
  assign res_o.face  = face2_q;

endmodule

### tb/tb_segment_face_id_matcher.sv
// Self-checking testbench for segment_face_id_matcher: clear, load and query words
// with random gaps, tolerance writes between phases, results checked against a predictor.
// Depends on sfim_pkg and the segment_face_id_matcher RTL.
`timescale 1ns / 1ps
module tb_segment_face_id_matcher;
  import sfim_pkg::*;

  localparam logic [1:0] CMD_ILLEGAL = 2'd3;

  typedef enum logic [1:0] {OP_WORD, OP_TOL, OP_DRAIN} op_kind_e;

  typedef struct {
    op_kind_e           kind;
    logic [1:0]         cmd;
    logic signed [31:0] sx, sy, sz, ex, ey, ez;
    logic [15:0]        face;
    logic [15:0]        tol;
    int                 gap;
  } op_t;

  typedef struct {
    logic               matched;
    logic signed [16:0] face_id;
  } match_t;

  typedef struct {
    logic signed [31:0] sx, sy, sz, ex, ey, ez;
    logic [15:0]        face;
  } seg_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         cmd_i = CMD_CLEAR;
  logic signed [31:0] start_x_i = '0, start_y_i = '0, start_z_i = '0;
  logic signed [31:0] end_x_i = '0, end_y_i = '0, end_z_i = '0;
  logic [15:0]        source_face_i = '0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [15:0]        cfg_wdata_i = '0;
  logic               result_valid_o;
  logic               matched_o;
  logic signed [16:0] face_id_o;

  segment_face_id_matcher dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: its own copy of the segment table and the tolerance
  seg_t        ref_table [TABLE_DEPTH];
  int          ref_count = 0;
  logic [15:0] ref_tol = TOL_RESET;

  op_t    pending_ops[$];
  match_t expected_matches[$];
  int     mismatches = 0;
  bit     op_taken = 0;

  // Both points within tolerance, strict on the squared distance
  function automatic bit points_close(logic signed [31:0] ax, ay, az, bx, by, bz,
                                      logic [15:0] tol);
    longint dx, dy, dz, t;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    dz = longint'(az) - longint'(bz);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    if (dz < 0) dz = -dz;
    t = longint'(tol);
    if (dx > t || dy > t || dz > t) return 0;
    return dx * dx + dy * dy + dz * dz < t * t;
  endfunction

  // Apply one accepted command word; queries yield the expected match
  task automatic predict_word(logic [1:0] cmd, seg_t q);
    match_t m;
    bit fwd, rev;
    m.matched = 1'b0;
    m.face_id = FACE_NONE;
    case (cmd)
      CMD_CLEAR: ref_count = 0;
      CMD_LOAD: begin
        if (ref_count < TABLE_DEPTH) begin
          ref_table[ref_count] = q;
          ref_count++;
        end
      end
      CMD_QUERY: begin
        for (int i = 0; i < ref_count; i++) begin
          fwd = points_close(q.sx, q.sy, q.sz, ref_table[i].sx, ref_table[i].sy,
                             ref_table[i].sz, ref_tol) &&
                points_close(q.ex, q.ey, q.ez, ref_table[i].ex, ref_table[i].ey,
                             ref_table[i].ez, ref_tol);
          rev = points_close(q.sx, q.sy, q.sz, ref_table[i].ex, ref_table[i].ey,
                             ref_table[i].ez, ref_tol) &&
                points_close(q.ex, q.ey, q.ez, ref_table[i].sx, ref_table[i].sy,
                             ref_table[i].sz, ref_tol);
          if (fwd || rev) begin
            m.matched = 1'b1;
            m.face_id = {1'b0, ref_table[i].face};
            break;
          end
        end
        expected_matches.insert(expected_matches.size(), m);
      end
      default: ;
    endcase
  endtask

  // Acceptance and result checking at the rising edge
  always @(posedge clk_i) begin
    seg_t q;
    match_t m;
    if (rst_ni) begin
      if (start && !busy) begin
        q = '{start_x_i, start_y_i, start_z_i, end_x_i, end_y_i, end_z_i, source_face_i};
        predict_word(cmd_i, q);
        op_taken = 1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        ref_tol = cfg_wdata_i;
        op_taken = 1;
      end
      if (result_valid_o) begin
        if (expected_matches.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: matched=%0b face_id=%0d", matched_o, face_id_o);
        end else begin
          m = expected_matches.pop_front();
          if (matched_o !== m.matched || face_id_o !== m.face_id) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected matched=%0b face_id=%0d, got %0b / %0d",
                       m.matched, m.face_id, matched_o, face_id_o);
          end
        end
      end
    end
  end

  // Driver: works off pending_ops at the falling edge
  int gap_count = 0;
  int idle_count = 0;
  always @(negedge clk_i) begin
    logic nxt_start, nxt_cfg;
    op_t op;
    nxt_start = 1'b0;
    nxt_cfg = 1'b0;
    if (rst_ni) begin
      if (op_taken) begin
        void'(pending_ops.pop_front());
        op_taken = 0;
        gap_count = 0;
      end
      if (pending_ops.size() > 0) begin
        op = pending_ops[0];
        if (gap_count < op.gap) gap_count++;
        else begin
          case (op.kind)
            OP_WORD: begin
              nxt_start = 1'b1;
              cmd_i <= op.cmd;
              start_x_i <= op.sx; start_y_i <= op.sy; start_z_i <= op.sz;
              end_x_i <= op.ex; end_y_i <= op.ey; end_z_i <= op.ez;
              source_face_i <= op.face;
            end
            OP_TOL: begin
              nxt_cfg = 1'b1;
              cfg_wdata_i <= op.tol;
            end
            default: begin
              // hold off until every result is in and the block has settled
              if (expected_matches.size() == 0 && !busy) idle_count++;
              else idle_count = 0;
              if (idle_count >= 16) begin
                void'(pending_ops.pop_front());
                idle_count = 0;
                gap_count = 0;
              end
            end
          endcase
        end
      end
    end
    start <= nxt_start;
    cfg_valid_i <= nxt_cfg;
  end

  // Stimulus generation
  seg_t        loaded[$];
  logic [15:0] gen_tol = TOL_RESET;
  bit          no_gaps = 0;
  int          word_count = 0;

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic push_word(logic [1:0] cmd, seg_t s);
    op_t op;
    op = '{OP_WORD, cmd, s.sx, s.sy, s.sz, s.ex, s.ey, s.ez, s.face, 16'd0, pick_gap()};
    pending_ops.insert(pending_ops.size(), op);
    word_count++;
    if (cmd == CMD_CLEAR) loaded.delete();
    if (cmd == CMD_LOAD && loaded.size() < TABLE_DEPTH) loaded.insert(loaded.size(), s);
  endtask

  task automatic push_drain();
    op_t op;
    op = '{OP_DRAIN, CMD_CLEAR, 0, 0, 0, 0, 0, 0, 16'd0, 16'd0, 0};
    pending_ops.insert(pending_ops.size(), op);
  endtask

  task automatic push_tol(logic [15:0] v);
    op_t op;
    push_drain();
    op = '{OP_TOL, CMD_CLEAR, 0, 0, 0, 0, 0, 0, 16'd0, v, pick_gap()};
    pending_ops.insert(pending_ops.size(), op);
    gen_tol = v;
  endtask

  function automatic seg_t random_seg();
    seg_t s;
    s = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 16'($urandom)};
    return s;
  endfunction

  function automatic logic signed [31:0] jitter(logic signed [31:0] v);
    int r;
    r = int'(gen_tol) + 2;
    return v + ($urandom_range(0, 2 * r) - r);
  endfunction

  // Query close to a loaded segment, either direction
  function automatic seg_t near_query();
    seg_t e, q;
    e = loaded[$urandom_range(0, loaded.size() - 1)];
    q = e;
    if ($urandom_range(0, 1)) begin
      q.sx = e.ex; q.sy = e.ey; q.sz = e.ez;
      q.ex = e.sx; q.ey = e.sy; q.ez = e.sz;
    end
    q.sx = jitter(q.sx); q.sy = jitter(q.sy); q.sz = jitter(q.sz);
    q.ex = jitter(q.ex); q.ey = jitter(q.ey); q.ez = jitter(q.ez);
    q.face = 16'($urandom);
    return q;
  endfunction

  localparam logic signed [31:0] MIN32 = 32'sh8000_0000;
  localparam logic signed [31:0] MAX32 = 32'sh7fff_ffff;

  initial begin
    seg_t a, b, q;
    int nload, nquery, big_fills, r;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty table, extremes, reversal, boundary, illegal command, tolerance writes, clear
    a = '{MIN32, MAX32, MIN32, MAX32, MIN32, MAX32, 16'hffff};
    b = '{32'sd1000, -32'sd1000, 32'sd0, 32'sd2000, 32'sd5, -32'sd7, 16'h0000};
    push_word(CMD_QUERY, a);
    push_word(CMD_LOAD, a);
    push_word(CMD_LOAD, b);
    push_word(CMD_QUERY, a);
    q = '{MAX32, MIN32, MAX32, MIN32, MAX32, MIN32, 16'h0};
    push_word(CMD_QUERY, q);
    q = '{b.ex, b.ey, b.ez, b.sx, b.sy, b.sz, 16'h1};
    push_word(CMD_QUERY, q);
    q = b; q.sx = b.sx + 51;
    push_word(CMD_QUERY, q);
    q = b; q.sx = b.sx - 50;
    push_word(CMD_QUERY, q);
    q = b; q.sx = b.sx + 30; q.sy = b.sy + 30; q.sz = b.sz + 29;
    push_word(CMD_QUERY, q);
    q = '{-1, -1, -1, -1, -1, -1, 16'hffff};
    push_word(CMD_ILLEGAL, q);
    push_word(CMD_QUERY, b);
    push_tol(16'd0);
    push_word(CMD_QUERY, b);
    push_tol(16'hffff);
    q = b; q.sx = b.sx + 65534;
    push_word(CMD_QUERY, q);
    q = b; q.sx = b.sx - 40000; q.sy = b.sy + 40000;
    push_word(CMD_QUERY, q);
    push_word(CMD_CLEAR, b);
    push_word(CMD_QUERY, b);
    push_tol(16'd1);
    push_word(CMD_LOAD, b);
    push_word(CMD_QUERY, b);

    // Random: clear, load a run, query mostly near loaded segments
    big_fills = 0;
    while (word_count < 1700) begin
      if ($urandom_range(0, 5) == 0) begin
        r = $urandom_range(0, 3);
        push_tol(r == 0 ? 16'd0 : r == 1 ? 16'hffff : r == 2 ? 16'($urandom_range(1, 100))
                 : 16'($urandom));
      end
      if ($urandom_range(0, 9) == 0) push_drain();
      no_gaps = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 4) != 0) push_word(CMD_CLEAR, random_seg());
      if (big_fills < 3 && $urandom_range(0, 19) == 0) begin
        nload = $urandom_range(TABLE_DEPTH - 4, TABLE_DEPTH + 8);
        big_fills++;
      end else nload = $urandom_range(1, 24);
      for (int i = 0; i < nload; i++) push_word(CMD_LOAD, random_seg());
      nquery = $urandom_range(1, 10);
      for (int i = 0; i < nquery; i++) begin
        r = $urandom_range(0, 99);
        if (r < 75 && loaded.size() > 0) push_word(CMD_QUERY, near_query());
        else if (r < 95) push_word(CMD_QUERY, random_seg());
        else push_word(CMD_ILLEGAL, random_seg());
      end
    end

    wait (pending_ops.size() == 0);
    wait (expected_matches.size() == 0);
    repeat (TABLE_DEPTH + 40) @(posedge clk_i);
    if (mismatches == 0 && expected_matches.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Watchdog
  initial begin
    #50_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
